// File: sv/variable_record_ring_allocator_defines.svh
// Assertion macros shared by the ring allocator modules.
`ifndef VARIABLE_RECORD_RING_ALLOCATOR_DEFINES_SVH
`define VARIABLE_RECORD_RING_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define VRRA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("vrra: same-cycle check failed");
`define VRRA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("vrra: next-cycle check failed");
`else
`define VRRA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define VRRA_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// File: sv/vrra_pkg.sv
// Types, codes and controller/datapath interface structs for the ring allocator.
package vrra_pkg;

  localparam int SIZE_W   = 12;
  localparam int OFFSET_W = 12;
  localparam int LENGTH_W = 12;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESERVE = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_WRITE,
    OUT_PEEK
  } out_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_RSV_CHK,
    S_RSV_WR,
    S_RD,
    S_REL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic      in_load;
    logic      need_load;
    logic      need_from_mem;
    logic      commit_do;
    logic      rd_first;
    logic      rd_base;
    logic      rsv_wrap;
    logic      rsv_write;
    logic      rel_do;
    logic      out_load;
    status_t   out_status;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  size_zero;
    logic  empty;
    logic  pending;
    logic  rsv_fail;
    logic  rsv_wrap;
    logic  rd_mark;
    logic  out_busy;
  } sts_t;

endpackage

// File: sv/variable_record_ring_allocator.sv
// Variable-length record ring allocator: header bookkeeping for a byte ring.
// The sequencer handles one operation at a time and takes no new transaction until the result
// of the last is registered; each header lookup waits on the registered header RAM read, and a
// peek or release that meets a wrap mark reads the header again from the front.
// Reset clears write/read pointers, record count, pending flag and result valid; header RAM is not cleared.
module variable_record_ring_allocator #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] size, [15:12] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [11:0] offset, [23:12] length
  output logic [1:0]  m_tuser    // [1:0] status
);
  import vrra_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  status_t             status;
  logic [OFFSET_W-1:0] offset;
  logic [LENGTH_W-1:0] length;

  vrra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vrra_datapath #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .mode_in    (mode_t'(s_tuser)),
    .size_in    (s_tdata[SIZE_W-1:0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .status_out (status),
    .offset_out (offset),
    .length_out (length),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign m_tdata = {length, offset};
  assign m_tuser = status;

endmodule

// File: sv/vrra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vrra_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 512
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/vrra_datapath.sv
// Ring allocator datapath: pointers, record count, header RAM, size math, result register.
`include "variable_record_ring_allocator_defines.svh"
module vrra_datapath #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vrra_pkg::mode_t                   mode_in,
  input  logic [vrra_pkg::SIZE_W-1:0]       size_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vrra_pkg::status_t                 status_out,
  output logic [vrra_pkg::OFFSET_W-1:0]     offset_out,
  output logic [vrra_pkg::LENGTH_W-1:0]     length_out,
  input  vrra_pkg::cmd_t                    cmd,
  output vrra_pkg::sts_t                    sts
);
  import vrra_pkg::*;

  // Pointers are kept in units of alignment slots.
  localparam int FULL      = POOL_BYTES / ALIGN_BYTES;
  localparam int HDR_LIMIT = (POOL_BYTES - HEADER_BYTES) / ALIGN_BYTES;
  localparam int DEPTH     = (POOL_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW        = $clog2(FULL + 1);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int MAXX      = (1 << SIZE_W) - 1 + HEADER_BYTES + ALIGN_BYTES - 1;
  localparam int XW        = $clog2(MAXX + 1);
  localparam int NW        = $clog2(MAXX / ALIGN_BYTES + 1);
  localparam int EW        = ((SW > NW) ? SW : NW) + 1;
  // floor(x / ALIGN) as (x * RM) >> RS, exact for x < 2**XW since ALIGN <= 64 < 2**7
  localparam int RS        = XW + 7;
  localparam int RM        = ((1 << RS) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int MW        = $clog2(RM + 1);
  localparam int PW        = XW + MW;
  localparam int BW0       = $clog2(POOL_BYTES + HEADER_BYTES + 1);
  localparam int BW        = (BW0 > OFFSET_W) ? BW0 : OFFSET_W;

  mode_t             mode_r;
  logic [SIZE_W-1:0] size_r;
  logic [SW-1:0]     w;
  logic [SW-1:0]     r;
  logic [CW-1:0]     count;
  logic              pending;
  logic [NW-1:0]     pend_need;
  logic [NW-1:0]     need;

  logic [SIZE_W-1:0] rdata;
  logic [SIZE_W-1:0] need_src;
  logic [XW-1:0]     x;
  logic [PW-1:0]     prod;
  logic [NW-1:0]     n_calc;

  logic [EW-1:0]     w_e, r_e, n_e, pn_e;
  logic              full, behind, wrap_need;
  logic              mark_fits;
  logic              we;
  logic [SW-1:0]     wslot;
  logic [SIZE_W-1:0] wdata;
  logic              re;
  logic [SW-1:0]     rslot;
  logic [BW-1:0]     w_byte, r_byte;

  assign need_src = cmd.need_from_mem ? rdata : size_r;
  assign x        = XW'(need_src) + XW'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign prod     = PW'(x) * PW'(RM);
  assign n_calc   = NW'(prod >> RS);

  assign w_e  = EW'(w);
  assign r_e  = EW'(r);
  assign n_e  = EW'(need);
  assign pn_e = EW'(pend_need);

  assign full      = (w == r) && (count != '0);
  assign behind    = w < r;
  assign wrap_need = (w_e + n_e) > EW'(FULL);
  assign mark_fits = w <= SW'(HDR_LIMIT);

  // header RAM write: wrap mark at the old write point if a header fits there, then the new header
  assign we    = (cmd.rsv_wrap && mark_fits) || cmd.rsv_write;
  assign wslot = w;
  assign wdata = cmd.rsv_write ? size_r : '0;

  // reader restart at the front after a wrap mark or a tail too short for a header
  assign re    = cmd.rd_first || cmd.rd_base;
  assign rslot = (cmd.rd_base || (r > SW'(HDR_LIMIT))) ? '0 : r;

  vrra_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wslot[IW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (rslot[IW-1:0]),
    .rdata (rdata)
  );

  assign w_byte = BW'(w) * BW'(ALIGN_BYTES) + BW'(HEADER_BYTES);
  assign r_byte = BW'(r) * BW'(ALIGN_BYTES) + BW'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      mode_r <= mode_in;
      size_r <= size_in;
    end
    if (cmd.need_load) begin
      need <= n_calc;
    end
    if (cmd.rsv_write) begin
      pend_need <= need;
    end
    if (cmd.out_load) begin
      status_out <= cmd.out_status;
      case (cmd.out_kind)
        OUT_WRITE: begin
          offset_out <= w_byte[OFFSET_W-1:0];
          length_out <= '0;
        end
        OUT_PEEK: begin
          offset_out <= r_byte[OFFSET_W-1:0];
          length_out <= rdata;
        end
        default: begin
          offset_out <= '0;
          length_out <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w         <= '0;
      r         <= '0;
      count     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.rsv_wrap) begin
        w <= '0;
      end else if (cmd.commit_do) begin
        w <= SW'(w_e + pn_e);
      end
      if (cmd.rsv_write) begin
        pending <= 1'b1;
      end else if (cmd.commit_do) begin
        pending <= 1'b0;
      end
      if (re) begin
        r <= rslot;
      end else if (cmd.rel_do) begin
        r <= SW'(r_e + n_e);
      end
      if (cmd.commit_do) begin
        count <= count + 1'b1;
      end else if (cmd.rel_do) begin
        count <= count - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.mode      = mode_r;
    sts.size_zero = size_r == '0;
    sts.empty     = count == '0;
    sts.pending   = pending;
    sts.rsv_fail  = full || (behind ? ((r_e - w_e) < n_e) : (wrap_need && (r_e < n_e)));
    sts.rsv_wrap  = !full && !behind && wrap_need;
    sts.rd_mark   = (rdata == '0) && (r != '0);
    sts.out_busy  = out_valid && !out_ready;
  end

  `VRRA_ASSERT_IMP(a_wp_in_pool, clk, rst, 1'b1, w <= SW'(FULL))
  `VRRA_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `VRRA_ASSERT_IMP(a_hdr_write_fits, clk, rst, we, wslot <= SW'(HDR_LIMIT))

endmodule

// File: sv/vrra_ctrl.sv
// Ring allocator controller: operation sequencer driving the datapath.
`include "variable_record_ring_allocator_defines.svh"
module vrra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output vrra_pkg::cmd_t cmd,
  input  vrra_pkg::sts_t sts
);
  import vrra_pkg::*;

  state_t    state, state_next;
  status_t   resp_status, resp_status_next;
  out_kind_t resp_kind, resp_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= ST_OK;
      resp_kind   <= OUT_NONE;
    end else begin
      state       <= state_next;
      resp_status <= resp_status_next;
      resp_kind   <= resp_kind_next;
    end
  end

  always_comb begin
    state_next       = state;
    resp_status_next = resp_status;
    resp_kind_next   = resp_kind;
    cmd              = '0;
    in_ready         = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        unique case (sts.mode) inside
          MODE_RESERVE: begin
            cmd.need_load = 1'b1;
            if (sts.size_zero) begin
              resp_status_next = ST_NO_ROOM;
              resp_kind_next   = OUT_NONE;
              state_next       = S_RESP;
            end else begin
              state_next = S_RSV_CHK;
            end
          end
          MODE_COMMIT: begin
            cmd.commit_do    = sts.pending;
            resp_status_next = ST_OK;
            resp_kind_next   = OUT_NONE;
            state_next       = S_RESP;
          end
          MODE_PEEK, MODE_RELEASE: begin
            if (sts.empty) begin
              resp_status_next = ST_EMPTY;
              resp_kind_next   = OUT_NONE;
              state_next       = S_RESP;
            end else begin
              cmd.rd_first = 1'b1;
              state_next   = S_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RSV_CHK: begin
        if (sts.rsv_fail) begin
          resp_status_next = ST_NO_ROOM;
          resp_kind_next   = OUT_NONE;
          state_next       = S_RESP;
        end else begin
          cmd.rsv_wrap = sts.rsv_wrap;
          state_next   = S_RSV_WR;
        end
      end
      S_RSV_WR: begin
        cmd.rsv_write    = 1'b1;
        resp_status_next = ST_OK;
        resp_kind_next   = OUT_WRITE;
        state_next       = S_RESP;
      end
      S_RD: begin
        if (sts.rd_mark) begin
          // wrap mark at the read point: restart from the front
          cmd.rd_base = 1'b1;
        end else if (sts.mode == MODE_PEEK) begin
          resp_status_next = ST_OK;
          resp_kind_next   = OUT_PEEK;
          state_next       = S_RESP;
        end else begin
          cmd.need_load     = 1'b1;
          cmd.need_from_mem = 1'b1;
          state_next        = S_REL;
        end
      end
      S_REL: begin
        cmd.rel_do       = 1'b1;
        resp_status_next = ST_OK;
        resp_kind_next   = OUT_NONE;
        state_next       = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_status;
          cmd.out_kind   = resp_kind;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `VRRA_ASSERT_IMP(a_no_result_overwrite, clk, rst, cmd.out_load, !sts.out_busy)
  `VRRA_ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != S_IDLE)
  `VRRA_ASSERT_NXT(a_result_returns_idle, clk, rst, cmd.out_load, state == S_IDLE)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the variable record ring allocator.
module testbench;
  import vrra_pkg::*;

  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int ALIGN_BYTES  = 8;
  localparam int SLOTS        = (POOL_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int RANDOM_ITEMS = 1920;
  localparam int N_ROWS       = 28;

  typedef struct packed {
    status_t     st;
    logic [11:0] off;
    logic [11:0] len;
  } ring_answer_t;

  typedef struct packed {
    mode_t        op;
    logic [11:0]  sz;
    logic         typed;
    ring_answer_t ans;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // predicted allocator state
  logic [12:0] wr_ptr;
  logic [12:0] rd_ptr;
  logic [8:0]  rec_count;
  logic        rsv_open;
  logic [12:0] hdr_sizes [SLOTS];

  ring_answer_t answers_due [$];
  bit           failed = 1'b0;
  bit           steady = 1'b0;
  plan_row_t    plan [N_ROWS];

  variable_record_ring_allocator #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int unsigned align_up(int unsigned x);
    return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  function automatic int unsigned hdr_get(int unsigned pos);
    if (pos / ALIGN_BYTES < SLOTS) return hdr_sizes[SLOT_W'(pos / ALIGN_BYTES)];
    return 0;
  endfunction

  function automatic void hdr_put(int unsigned pos, int unsigned v);
    if (pos / ALIGN_BYTES < SLOTS) hdr_sizes[SLOT_W'(pos / ALIGN_BYTES)] = v[12:0];
  endfunction

  // Advance the predicted allocator by one transaction and return its answer.
  function automatic ring_answer_t ring_step(mode_t op, logic [11:0] sz);
    ring_answer_t a;
    int unsigned w, r, need, len;
    bit ok;
    a = '0;
    a.st = ST_OK;
    w = wr_ptr;
    r = rd_ptr;
    case (op)
      MODE_RESERVE: begin
        need = align_up(sz + HEADER_BYTES);
        ok = 1'b1;
        if (sz == 0) begin
          ok = 1'b0;  // zero length would look like a wrap mark
        end else if (w == r && rec_count != 0) begin
          ok = 1'b0;
        end else if (w < r) begin
          if (r - w < need) ok = 1'b0;
        end else if (w > POOL_BYTES || POOL_BYTES - w < need) begin
          if (r < need) begin
            ok = 1'b0;
          end else begin
            if (w <= POOL_BYTES && POOL_BYTES - w >= HEADER_BYTES) hdr_put(w, 0);
            w = 0;
          end
        end
        if (ok) begin
          wr_ptr = 13'(w);
          hdr_put(w, sz);
          rsv_open = 1'b1;
          a.off = 12'(w + HEADER_BYTES);
        end else begin
          a.st = ST_NO_ROOM;
        end
      end
      MODE_COMMIT: begin
        if (rsv_open) begin
          wr_ptr = 13'(w + align_up(hdr_get(w) + HEADER_BYTES));
          rec_count = rec_count + 9'd1;
          rsv_open = 1'b0;
        end
      end
      default: begin
        if (rec_count == 0) begin
          a.st = ST_EMPTY;
        end else begin
          // short tail or wrap mark: oldest record sits at the front
          if (r > POOL_BYTES || POOL_BYTES - r < HEADER_BYTES || hdr_get(r) == 0) r = 0;
          rd_ptr = 13'(r);
          len = hdr_get(r);
          if (op == MODE_PEEK) begin
            a.off = 12'(r + HEADER_BYTES);
            a.len = len[11:0];
          end else begin
            rd_ptr = 13'(r + align_up(len + HEADER_BYTES));
            rec_count = rec_count - 9'd1;
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic logic [11:0] pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 12'($urandom_range(64, 1));
    if (p < 88) return 12'($urandom_range(600, 1));
    if (p < 97) return 12'($urandom_range(4095, 0));
    return (p == 97) ? 12'd0 : 12'hFFF;
  endfunction

  task automatic send_op(mode_t op, logic [11:0] sz, bit typed, ring_answer_t fixed);
    ring_answer_t pred;
    while (!steady && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'd0, sz};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = ring_step(op, sz);
    answers_due.push_back(typed ? fixed : pred);
  endtask

  // result side: check each transaction, random backpressure outside the steady phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h", $time, m_tuser, m_tdata);
          failed = 1'b1;
        end else begin
          ring_answer_t e;
          e = answers_due.pop_front();
          if (m_tuser !== e.st || m_tdata[11:0] !== e.off || m_tdata[23:12] !== e.len) begin
            $display("%0t: mismatch expected status=%0d offset=%0d length=%0d,",
                     $time, e.st, e.off, e.len,
                     " got status=%0d offset=%0d length=%0d",
                     m_tuser, m_tdata[11:0], m_tdata[23:12]);
            failed = 1'b1;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned sent, p, pair_w;
    bit filling, drained;
    wr_ptr    = '0;
    rd_ptr    = '0;
    rec_count = '0;
    rsv_open  = 1'b0;
    foreach (hdr_sizes[i]) hdr_sizes[i] = '0;
    plan = '{
      '{MODE_PEEK,    12'd0,    1'b1, '{ST_EMPTY,   12'd0, 12'd0}},
      '{MODE_RELEASE, 12'd0,    1'b1, '{ST_EMPTY,   12'd0, 12'd0}},
      '{MODE_COMMIT,  12'd0,    1'b1, '{ST_OK,      12'd0, 12'd0}},  // nothing pending
      '{MODE_RESERVE, 12'd0,    1'b1, '{ST_NO_ROOM, 12'd0, 12'd0}},
      '{MODE_RESERVE, 12'd4095, 1'b1, '{ST_NO_ROOM, 12'd0, 12'd0}},
      '{MODE_RESERVE, 12'd1,    1'b1, '{ST_OK,      12'd8, 12'd0}},
      '{MODE_RESERVE, 12'd100,  1'b1, '{ST_OK,      12'd8, 12'd0}},  // replaces pending
      '{MODE_COMMIT,  12'd0,    1'b1, '{ST_OK,      12'd0, 12'd0}},
      '{MODE_PEEK,    12'd0,    1'b1, '{ST_OK,      12'd8, 12'd100}},
      '{MODE_RELEASE, 12'd0,    1'b1, '{ST_OK,      12'd0, 12'd0}},
      '{MODE_RESERVE, 12'd3000, 1'b0, '0},
      '{MODE_COMMIT,  12'd0,    1'b0, '0},
      '{MODE_RESERVE, 12'd1000, 1'b0, '0},  // short tail, reader too low to wrap
      '{MODE_RELEASE, 12'd0,    1'b0, '0},
      '{MODE_RESERVE, 12'd1000, 1'b0, '0},  // wraps, leaves a mark
      '{MODE_COMMIT,  12'd0,    1'b0, '0},
      '{MODE_PEEK,    12'd0,    1'b0, '0},  // reader steps over the mark
      '{MODE_RESERVE, 12'd2072, 1'b0, '0},
      '{MODE_COMMIT,  12'd0,    1'b0, '0},
      '{MODE_RESERVE, 12'd1000, 1'b0, '0},
      '{MODE_COMMIT,  12'd0,    1'b0, '0},  // write point at end of pool
      '{MODE_RESERVE, 12'd8,    1'b0, '0},
      '{MODE_RELEASE, 12'd0,    1'b0, '0},
      '{MODE_RESERVE, 12'd1000, 1'b0, '0},  // wraps, tail too short for a mark
      '{MODE_COMMIT,  12'd0,    1'b0, '0},  // ring full
      '{MODE_RESERVE, 12'd1,    1'b0, '0},
      '{MODE_RELEASE, 12'd0,    1'b0, '0},
      '{MODE_RESERVE, 12'd2080, 1'b0, '0}   // writer behind reader, gap too small
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) send_op(plan[i].op, plan[i].sz, plan[i].typed, plan[i].ans);

    sent    = 0;
    filling = 1'b1;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(49) == 0) filling = !filling;
      steady = (sent >= 600 && sent < 900);
      if (!drained && sent >= 1000) begin
        // hold off until the block has answered everything
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      p = $urandom_range(99);
      pair_w = filling ? 55 : 20;
      if (p < pair_w) begin
        send_op(MODE_RESERVE, pick_size(), 1'b0, '0);
        send_op(MODE_COMMIT, 12'($urandom), 1'b0, '0);
        sent += 2;
      end else begin
        if (p < pair_w + 8)       send_op(MODE_RESERVE, pick_size(), 1'b0, '0);
        else if (p < pair_w + 13) send_op(MODE_COMMIT, 12'($urandom), 1'b0, '0);
        else if (p < pair_w + 28) send_op(MODE_PEEK, 12'($urandom), 1'b0, '0);
        else                      send_op(MODE_RELEASE, 12'($urandom), 1'b0, '0);
        sent += 1;
      end
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (answers_due.size() != 0) $display("%0d results never arrived", answers_due.size());
    if (!failed && answers_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/vrra_pkg.sv
sv/vrra_ram.sv
sv/vrra_datapath.sv
sv/vrra_ctrl.sv
sv/variable_record_ring_allocator.sv
tb/testbench.sv
